@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// ante in a cycle implies cons in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// ante in a cycle implies cons in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/cpl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpl_pkg
// Shared constants for the core point labeler: widths, defaults, reg indexes.
// ----------------------------------------------------------------------------
package cpl_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 16;

    localparam int COORD_W    = 16;  // port width of x/y
    localparam int RADIUS_W   = 16;
    localparam int MINN_W     = 6;
    localparam int IDX_OUT_W  = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int HIT_CNT_W  = 7;   // neighbor count, at most 63 others

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_NEIGHBORS = 2'd1;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 16'd64;
    localparam logic [MINN_W-1:0]   MINN_RST   = 6'd4;

endpackage

@@ hdl/core_point_labeler.sv @@
`timescale 1ns / 1ps
// Load: one point per cycle; busy stays low while points are loaded.
// Labeling of n stored points: one distance compare per cycle through a single
// shared diff/square/compare pipe, except where each point's center is fetched;
// each point is compared against all n stored points, itself masked out.
// Results come one per point, strobed on o_valid; the receiver cannot stall.
// Reset (synchronous, active low) clears the fill count and the sequencer and
// restores radius 64 and min_neighbors 4; the point store is not cleared.
// ----------------------------------------------------------------------------
// core_point_labeler
// Stores a 2-D point set and labels each point core or not by neighbor count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module core_point_labeler
    import cpl_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_W-1:0]    i_x_coord,
    input  logic [COORD_W-1:0]    i_y_coord,
    input  logic                  i_last_point,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_valid,
    output logic [IDX_OUT_W-1:0]  o_point_index,
    output logic                  o_is_core,
    output logic                  o_last_result
);

    localparam int AW     = $clog2(MAX_POINTS);
    localparam int LD_W   = $clog2(MAX_POINTS + 1);
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int SUM_W  = SQ_W + 1;
    localparam int LIM_W  = 2 * RADIUS_W;
    localparam int CMP_W  = (SUM_W > LIM_W) ? SUM_W : LIM_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    // configuration
    logic [RADIUS_W-1:0] r_radius;
    logic [LIM_W-1:0]    r_limit;
    logic [MINN_W-1:0]   r_min_nb;

    // point store, {y, x}
    logic [2*COORD_BITS-1:0] r_mem [MAX_POINTS];

    // sequencer
    logic [1:0]      r_state, n_state;
    logic [LD_W-1:0] r_loaded, n_loaded;
    logic [LD_W-1:0] r_n, n_n;
    logic [AW-1:0]   r_i, n_i;
    logic [AW-1:0]   r_j, n_j;
    logic            r_center, n_center;

    logic            w_accept;
    logic            w_full;
    logic            w_store;
    logic            w_trigger;
    logic            w_issue;
    logic [AW-1:0]   w_addr;
    logic            w_skip;
    logic            w_last_j;
    logic            w_last_i;
    logic [LD_W-1:0] w_n_m1;

    // pipe stage 0: read data
    logic                    r_s0_v, r_s0_center, r_s0_skip, r_s0_last_j, r_s0_last_i;
    logic [AW-1:0]           r_s0_idx;
    logic [2*COORD_BITS-1:0] r_rdata;
    // center point
    logic [COORD_BITS-1:0]   r_cx, r_cy;
    // stage 1: abs diffs
    logic                    r_s1_v, r_s1_skip, r_s1_last_j, r_s1_last_i;
    logic [AW-1:0]           r_s1_idx;
    logic [COORD_BITS-1:0]   r_dx, r_dy;
    // stage 2: squares
    logic                    r_s2_v, r_s2_skip, r_s2_last_j, r_s2_last_i;
    logic [AW-1:0]           r_s2_idx;
    logic [SQ_W-1:0]         r_sqx, r_sqy;
    // stage 3: hit
    logic                    r_s3_v, r_s3_hit, r_s3_last_j, r_s3_last_i;
    logic [AW-1:0]           r_s3_idx;
    // stage 4: count and emit
    logic [HIT_CNT_W-1:0]    r_cnt;
    logic [HIT_CNT_W-1:0]    w_cnt_fin;

    logic                    r_out_valid;
    logic [IDX_OUT_W-1:0]    r_out_idx;
    logic                    r_out_core;
    logic                    r_out_last;

    logic [COORD_BITS-1:0]   w_px, w_py;
    logic [SUM_W-1:0]        w_sum;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST;
            r_min_nb <= MINN_RST;
            r_limit  <= LIM_W'(RADIUS_RST) * LIM_W'(RADIUS_RST);
        end else begin
            r_limit <= LIM_W'(r_radius) * LIM_W'(r_radius);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RADIUS: begin
                        r_radius <= i_cfg_data[RADIUS_W-1:0];
                    end
                    REG_MIN_NEIGHBORS: begin
                        // saturate zero to one
                        if (i_cfg_data[MINN_W-1:0] == '0) begin
                            r_min_nb <= MINN_W'(1);
                        end else begin
                            r_min_nb <= i_cfg_data[MINN_W-1:0];
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign busy      = (r_state != ST_IDLE) || r_out_valid;
    assign w_accept  = start && !busy;
    assign w_full    = (r_loaded >= LD_W'(MAX_POINTS));
    assign w_store   = w_accept && !w_full;
    assign w_trigger = w_accept && (w_full || i_last_point);

    assign w_issue   = (r_state == ST_RUN);
    assign w_addr    = r_center ? r_i : r_j;
    assign w_n_m1    = r_n - LD_W'(1);
    assign w_skip    = (r_j == r_i);
    assign w_last_j  = (LD_W'(r_j) == w_n_m1);
    assign w_last_i  = (LD_W'(r_i) == w_n_m1);

    assign w_px = COORD_BITS'(i_x_coord);
    assign w_py = COORD_BITS'(i_y_coord);

    always_comb begin
        n_state  = r_state;
        n_loaded = r_loaded;
        n_n      = r_n;
        n_i      = r_i;
        n_j      = r_j;
        n_center = r_center;
        case (r_state)
            ST_IDLE: begin
                if (w_store) begin
                    n_loaded = r_loaded + LD_W'(1);
                end
                if (w_trigger) begin
                    n_n      = w_full ? r_loaded : (r_loaded + LD_W'(1));
                    n_loaded = '0;
                    n_i      = '0;
                    n_j      = '0;
                    n_center = 1'b1;
                    n_state  = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_center) begin
                    n_center = 1'b0;
                end else if (w_last_j) begin
                    // wrap to next point, fetch its center first; after the last point, drain
                    n_j      = '0;
                    n_center = 1'b1;
                    if (w_last_i) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_i = r_i + AW'(1);
                    end
                end else begin
                    n_j = r_j + AW'(1);
                end
            end
            ST_DRAIN: begin
                if (r_s3_v && r_s3_last_j && r_s3_last_i) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_loaded <= '0;
            r_n      <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_center <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_loaded <= n_loaded;
            r_n      <= n_n;
            r_i      <= n_i;
            r_j      <= n_j;
            r_center <= n_center;
        end
    end

    // ------------------------------------------------------------------
    // point store
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_mem[r_loaded[AW-1:0]] <= {w_py, w_px};
        end
        r_rdata <= r_mem[w_addr];
    end

    // ------------------------------------------------------------------
    // compare pipe
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            r_s0_v <= w_issue;
            r_s1_v <= r_s0_v && !r_s0_center;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    assign w_sum = SUM_W'(r_sqx) + SUM_W'(r_sqy);

    always_ff @(posedge i_clk) begin
        r_s0_center <= r_center;
        r_s0_skip   <= w_skip;
        r_s0_last_j <= w_last_j;
        r_s0_last_i <= w_last_i;
        r_s0_idx    <= r_i;

        // latch the center point
        if (r_s0_v && r_s0_center) begin
            r_cx <= r_rdata[COORD_BITS-1:0];
            r_cy <= r_rdata[2*COORD_BITS-1:COORD_BITS];
        end

        r_dx <= (r_cx >= r_rdata[COORD_BITS-1:0]) ?
                (r_cx - r_rdata[COORD_BITS-1:0]) : (r_rdata[COORD_BITS-1:0] - r_cx);
        r_dy <= (r_cy >= r_rdata[2*COORD_BITS-1:COORD_BITS]) ?
                (r_cy - r_rdata[2*COORD_BITS-1:COORD_BITS]) :
                (r_rdata[2*COORD_BITS-1:COORD_BITS] - r_cy);
        r_s1_skip   <= r_s0_skip;
        r_s1_last_j <= r_s0_last_j;
        r_s1_last_i <= r_s0_last_i;
        r_s1_idx    <= r_s0_idx;

        r_sqx       <= SQ_W'(r_dx) * SQ_W'(r_dx);
        r_sqy       <= SQ_W'(r_dy) * SQ_W'(r_dy);
        r_s2_skip   <= r_s1_skip;
        r_s2_last_j <= r_s1_last_j;
        r_s2_last_i <= r_s1_last_i;
        r_s2_idx    <= r_s1_idx;

        r_s3_hit    <= !r_s2_skip && (CMP_W'(w_sum) <= CMP_W'(r_limit));
        r_s3_last_j <= r_s2_last_j;
        r_s3_last_i <= r_s2_last_i;
        r_s3_idx    <= r_s2_idx;
    end

    // ------------------------------------------------------------------
    // neighbor count and result
    // ------------------------------------------------------------------
    assign w_cnt_fin = r_cnt + HIT_CNT_W'(r_s3_hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_s3_v && r_s3_last_j;
            if (r_s3_v) begin
                if (r_s3_last_j) begin
                    r_cnt <= '0;
                end else begin
                    r_cnt <= w_cnt_fin;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s3_v && r_s3_last_j) begin
            r_out_idx  <= IDX_OUT_W'(r_s3_idx);
            r_out_core <= (w_cnt_fin >= HIT_CNT_W'(r_min_nb));
            r_out_last <= r_s3_last_i;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_point_index = r_out_idx;
    assign o_is_core     = r_out_core;
    assign o_last_result = r_out_last;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ASSERT_ALWAYS(a_loaded_bound, i_clk, i_rst_n, r_loaded <= LD_W'(MAX_POINTS), "fill count over capacity")
    `ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, r_cnt < HIT_CNT_W'(MAX_POINTS), "neighbor count overflow")
    `ASSERT_IMPLIES(a_out_busy, i_clk, i_rst_n, r_out_valid, busy, "result beat while idle")
    `ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, r_out_valid && r_out_last, !r_out_valid && r_state == ST_IDLE, "beat after last result")

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Core point labeler testbench
// Loads point sets through the command port and predicts the core label of
// every stored point. Each result beat is checked in order against the
// scoreboard. Runs directed sets, then random sets under several register
// settings and sender idle patterns.
// ----------------------------------------------------------------------------
module testbench;
    import cpl_pkg::*;

    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 400000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] index;
        logic                 core;
        logic                 last;
    } t_label;

    class core_label_board;
        logic [RADIUS_W-1:0] radius;
        logic [MINN_W-1:0]   min_nbrs;
        logic [COORD_W-1:0]  xs [MAX_POINTS_DEF];
        logic [COORD_W-1:0]  ys [MAX_POINTS_DEF];
        int unsigned         n_stored;
        t_label              pending_labels [$];
        int unsigned         mismatches;

        function new();
            radius     = RADIUS_RST;
            min_nbrs   = MINN_RST;
            n_stored   = 0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_RADIUS: begin
                    radius = data[RADIUS_W-1:0];
                end
                REG_MIN_NEIGHBORS: begin
                    // a zero count saturates to one
                    min_nbrs = data[MINN_W-1:0];
                    if (min_nbrs == '0)
                        min_nbrs = MINN_W'(1);
                end
                default: begin
                end
            endcase
        endfunction

        function void label_set();
            logic [33:0] lim, ex, ey, d2;
            int unsigned cnt;
            bit          is_core;
            t_label      lbl;
            lim = {18'd0, radius} * {18'd0, radius};
            for (int i = 0; i < n_stored; i++) begin
                cnt     = 0;
                is_core = 0;
                // stop counting once the label is settled
                for (int j = 0; j < n_stored && !is_core; j++) begin
                    if (j == i)
                        continue;
                    ex = {18'd0, (xs[i] >= xs[j]) ? xs[i] - xs[j] : xs[j] - xs[i]};
                    ey = {18'd0, (ys[i] >= ys[j]) ? ys[i] - ys[j] : ys[j] - ys[i]};
                    d2 = ex * ex + ey * ey;
                    if (d2 <= lim)
                        cnt++;
                    if (cnt >= 32'(min_nbrs))
                        is_core = 1;
                end
                lbl.index = i[IDX_OUT_W-1:0];
                lbl.core  = is_core;
                lbl.last  = (i == n_stored - 1);
                pending_labels = {pending_labels, lbl};
            end
            n_stored = 0;
        endfunction

        function void note_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic last);
            bit fire;
            fire = last;
            // a point past capacity closes the set and is dropped
            if (n_stored >= MAX_POINTS_DEF) begin
                fire = 1;
            end else begin
                xs[n_stored] = x;
                ys[n_stored] = y;
                n_stored++;
            end
            if (fire)
                label_set();
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 50)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_label(logic [IDX_OUT_W-1:0] index, logic core, logic last);
            t_label want;
            if (pending_labels.size() == 0) begin
                report($sformatf("unexpected result beat, index %0d", index));
                return;
            end
            want = pending_labels.pop_front();
            if (index !== want.index)
                report($sformatf("point_index %0d, want %0d", index, want.index));
            if (core !== want.core)
                report($sformatf("is_core %b on index %0d, want %b", core, want.index,
                                 want.core));
            if (last !== want.last)
                report($sformatf("last_result %b on index %0d, want %b", last, want.index,
                                 want.last));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [COORD_W-1:0]    i_x_coord;
    logic [COORD_W-1:0]    i_y_coord;
    logic                  i_last_point;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_valid;
    logic [IDX_OUT_W-1:0]  o_point_index;
    logic                  o_is_core;
    logic                  o_last_result;

    core_label_board board = new();
    int              items_sent = 0;
    int              cycle_count = 0;

    core_point_labeler u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_x_coord     (i_x_coord),
        .i_y_coord     (i_y_coord),
        .i_last_point  (i_last_point),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_point_index (o_point_index),
        .o_is_core     (o_is_core),
        .o_last_result (o_last_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            board.check_label(o_point_index, o_is_core, o_last_result);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Called at a falling edge; leaves start high with the accepted beat so a
    // back-to-back beat can follow without a gap.
    task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic last);
        i_x_coord    = x;
        i_y_coord    = y;
        i_last_point = last;
        start        = 1'b1;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        board.note_point(x, y, last);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic pause_sender(input int cycles);
        start = 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic sender_gap(input int pct);
        if ($urandom_range(99) < pct)
            pause_sender($urandom_range(1, 4));
    endtask

    // Hold off until every label has come back and the block has settled.
    task automatic drain_labels();
        start = 1'b0;
        while (board.pending_labels.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        board.write_reg(idx, data);
        i_cfg_we   = 1'b0;
    endtask

    function automatic logic [COORD_W-1:0] near(input logic [COORD_W-1:0] c, input int spread);
        int v;
        v = int'(c) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[COORD_W-1:0];
    endfunction

    // Send a set of n points; with overflow the set is closed by one extra beat
    // past capacity instead of the last mark.
    task automatic send_set(input int n, input bit overflow, input int pct);
        logic [COORD_W-1:0] cx, cy, px, py;
        bit                 clustered;
        int                 spread;
        cx        = COORD_W'($urandom);
        cy        = COORD_W'($urandom);
        clustered = ($urandom_range(99) < 75);
        if (board.radius == 0)
            spread = $urandom_range(0, 1);
        else if (board.radius > 3000)
            spread = 3000;
        else
            spread = int'(board.radius);
        for (int k = 0; k < n; k++) begin
            if (clustered && $urandom_range(9) != 0) begin
                px = near(cx, spread);
                py = near(cy, spread);
            end else begin
                px = COORD_W'($urandom);
                py = COORD_W'($urandom);
            end
            send_point(px, py, (k == n - 1) && !overflow);
            sender_gap(pct);
        end
        if (overflow) begin
            send_point(COORD_W'($urandom), COORD_W'($urandom), $urandom_range(1) != 0);
            sender_gap(pct);
        end
    endtask

    task automatic run_phase(input int quota, input int pct, input bit force_overflow);
        int goal, pick;
        goal = items_sent + quota;
        if (force_overflow)
            send_set(MAX_POINTS_DEF, 1'b1, pct);
        while (items_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 2)
                send_set(MAX_POINTS_DEF, 1'b1, pct);
            else if (pick < 4)
                send_set($urandom_range(40, MAX_POINTS_DEF), 1'b0, pct);
            else if (pick < 6)
                drain_labels();
            else if (pick < 18)
                send_set($urandom_range(11, 24), 1'b0, pct);
            else
                send_set($urandom_range(1, 10), 1'b0, pct);
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_x_coord    = '0;
        i_y_coord    = '0;
        i_last_point = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = REG_RADIUS;
        i_cfg_data   = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset settings: a small cluster around the origin and a far corner
        send_point(16'd0, 16'd0, 1'b0);
        send_point(16'd64, 16'd0, 1'b0);
        send_point(16'd0, 16'd64, 1'b0);
        send_point(16'd45, 16'd45, 1'b0);
        send_point(16'd32, 16'd32, 1'b0);
        send_point(16'hFFFF, 16'hFFFF, 1'b1);
        // lone point set
        send_point(16'hFFFF, 16'h0000, 1'b1);
        drain_labels();

        // spare indexes are ignored; a zero count saturates
        write_cfg(REG_SPARE_A, 16'hFFFF);
        write_cfg(REG_SPARE_B, 16'h0001);
        write_cfg(REG_MIN_NEIGHBORS, 16'hFFC0);
        write_cfg(REG_RADIUS, 16'h0000);
        send_point(16'd1234, 16'd4321, 1'b0);
        send_point(16'd1234, 16'd4321, 1'b0);
        send_point(16'd1235, 16'd4321, 1'b0);
        send_point(16'd0, 16'd0, 1'b1);
        drain_labels();

        // full radius: edge distance exactly on the limit, diagonal beyond it
        write_cfg(REG_RADIUS, 16'hFFFF);
        write_cfg(REG_MIN_NEIGHBORS, 16'h0002);
        send_point(16'h0000, 16'h0000, 1'b0);
        send_point(16'hFFFF, 16'h0000, 1'b0);
        send_point(16'hFFFF, 16'hFFFF, 1'b0);
        send_point(16'h0000, 16'hFFFF, 1'b0);
        send_point(16'h8000, 16'h8000, 1'b1);
        drain_labels();

        write_cfg(REG_RADIUS, 16'h0001);
        write_cfg(REG_MIN_NEIGHBORS, 16'h003F);
        send_point(16'd7, 16'd7, 1'b0);
        send_point(16'd8, 16'd7, 1'b0);
        send_point(16'd9, 16'd9, 1'b1);
        drain_labels();

        write_cfg(REG_RADIUS, CFG_DATA_W'($urandom_range(100, 2000)));
        write_cfg(REG_MIN_NEIGHBORS, CFG_DATA_W'($urandom_range(1, 6)));
        run_phase(75, 0, 1'b0);
        drain_labels();

        write_cfg(REG_RADIUS, 16'hFFFF);
        write_cfg(REG_MIN_NEIGHBORS, 16'h003F);
        run_phase(75, 62, 1'b1);
        drain_labels();

        write_cfg(REG_RADIUS, 16'h0000);
        write_cfg(REG_MIN_NEIGHBORS, 16'h0000);
        run_phase(70, 0, 1'b0);
        drain_labels();

        write_cfg(REG_RADIUS, CFG_DATA_W'($urandom_range(0, 65535)));
        write_cfg(REG_MIN_NEIGHBORS, CFG_DATA_W'($urandom_range(1, 8)));
        run_phase(70, 13, 1'b0);
        drain_labels();

        if (board.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/cpl_pkg.sv
hdl/core_point_labeler.sv
dv/testbench.sv
